>>> rtl/core/sc2a_pkg.sv
package sc2a_pkg;

  // scan code set 1 byte values
  localparam logic [7:0] PREFIX_BYTE  = 8'hE0;
  localparam logic [7:0] ROM_ROWS     = 8'h3B;
  localparam logic [6:0] CAPS_MAKE    = 7'h3A;
  localparam logic [6:0] LSHIFT_MAKE  = 7'h2A;
  localparam logic [6:0] RSHIFT_MAKE  = 7'h36;
  localparam logic [6:0] CTRL_MAKE    = 7'h1D;
  localparam logic [6:0] ALT_MAKE     = 7'h38;
  localparam logic [6:0] FIRST_LETTER = 7'h0E;

  // one decoded result beat
  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       unknown_key;
    logic       ctrl_down;
    logic       shift_down;
    logic       alt_down;
    logic       caps_on;
  } result_t;

  // character table: {shifted, plain} per make code
  function automatic logic [13:0] key_rom(input logic [5:0] row);
    logic [13:0] ent;
    unique case (row)
      6'h01: ent = {7'h1B, 7'h1B};
      6'h02: ent = {7'h21, 7'h31};
      6'h03: ent = {7'h40, 7'h32};
      6'h04: ent = {7'h23, 7'h33};
      6'h05: ent = {7'h24, 7'h34};
      6'h06: ent = {7'h25, 7'h35};
      6'h07: ent = {7'h5E, 7'h36};
      6'h08: ent = {7'h26, 7'h37};
      6'h09: ent = {7'h2A, 7'h38};
      6'h0A: ent = {7'h28, 7'h39};
      6'h0B: ent = {7'h29, 7'h30};
      6'h0C: ent = {7'h5F, 7'h2D};
      6'h0D: ent = {7'h2B, 7'h3D};
      6'h0E: ent = {7'h08, 7'h08};
      6'h0F: ent = {7'h09, 7'h09};
      6'h10: ent = {7'h51, 7'h71};
      6'h11: ent = {7'h57, 7'h77};
      6'h12: ent = {7'h45, 7'h65};
      6'h13: ent = {7'h52, 7'h72};
      6'h14: ent = {7'h54, 7'h74};
      6'h15: ent = {7'h59, 7'h79};
      6'h16: ent = {7'h55, 7'h75};
      6'h17: ent = {7'h49, 7'h69};
      6'h18: ent = {7'h4F, 7'h6F};
      6'h19: ent = {7'h50, 7'h70};
      6'h1A: ent = {7'h7B, 7'h5B};
      6'h1B: ent = {7'h7D, 7'h5D};
      6'h1C: ent = {7'h0D, 7'h0D};
      6'h1E: ent = {7'h41, 7'h61};
      6'h1F: ent = {7'h53, 7'h73};
      6'h20: ent = {7'h44, 7'h64};
      6'h21: ent = {7'h46, 7'h66};
      6'h22: ent = {7'h47, 7'h67};
      6'h23: ent = {7'h48, 7'h68};
      6'h24: ent = {7'h4A, 7'h6A};
      6'h25: ent = {7'h4B, 7'h6B};
      6'h26: ent = {7'h4C, 7'h6C};
      6'h27: ent = {7'h3A, 7'h3B};
      6'h28: ent = {7'h22, 7'h27};
      6'h29: ent = {7'h7E, 7'h60};
      6'h2B: ent = {7'h7C, 7'h5C};
      6'h2C: ent = {7'h5A, 7'h7A};
      6'h2D: ent = {7'h58, 7'h78};
      6'h2E: ent = {7'h43, 7'h63};
      6'h2F: ent = {7'h56, 7'h76};
      6'h30: ent = {7'h42, 7'h62};
      6'h31: ent = {7'h4E, 7'h6E};
      6'h32: ent = {7'h4D, 7'h6D};
      6'h33: ent = {7'h3C, 7'h2C};
      6'h34: ent = {7'h3E, 7'h2E};
      6'h35: ent = {7'h3F, 7'h2F};
      6'h37: ent = {7'h2A, 7'h2A};
      6'h39: ent = {7'h20, 7'h20};
      default: ent = 14'h0;
    endcase
    return ent;
  endfunction

  // digit and punctuation keys: only shift picks the second column
  function automatic logic shift_only_key(input logic [6:0] code);
    return (code < FIRST_LETTER) || code == 7'h29 || code == 7'h1A ||
           code == 7'h1B || code == 7'h2B || code == 7'h27 || code == 7'h28 ||
           code == 7'h33 || code == 7'h34 || code == 7'h35;
  endfunction

endpackage

>>> rtl/core/sc2a_scan_if.sv
interface sc2a_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

>>> rtl/core/sc2a_char_if.sv
interface sc2a_char_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [6:0] char_code;
  logic       unknown_key;
  logic       ctrl_down;
  logic       shift_down;
  logic       alt_down;
  logic       caps_on;

  modport source (output valid, output char_valid, output char_code, output unknown_key,
                  output ctrl_down, output shift_down, output alt_down, output caps_on,
                  input ready);
  modport sink (input valid, input char_valid, input char_code, input unknown_key,
                input ctrl_down, input shift_down, input alt_down, input caps_on,
                output ready);
endinterface

>>> rtl/core/scan_code_to_ascii_decoder_top.sv
// Scan code set 1 keyboard decoder.
// Channel scan carries one raw keyboard byte per beat; channel chars returns
// exactly one result beat per accepted byte: an ASCII character when one is
// produced, an unknown-key flag, and the ctrl, shift, alt and caps lock state
// as it stands after that byte. A 0xE0 byte only arms the extended prefix.
// The result is registered: it is held in the result register, or in the skid register behind a stalled result.
// Throughput: one byte per cycle while chars is not stalled; the table lookup and flag update sit between
// the accept edge and the result register, so nothing limits the rate below one.
// A stalled receiver does not stop input at once: one further byte is taken
// into a skid register, after which scan ready drops until chars drains.
// Reset (rst, synchronous, active high) clears all modifier flags and the prefix
// flag and empties both result registers; scan ready is high in the first cycle after.
module scan_code_to_ascii_decoder_top
  import sc2a_pkg::*;
(
  input logic             clk,
  input logic             rst,
  sc2a_scan_if.sink       scan,
  sc2a_char_if.source     chars
);

  logic    ctrl_flag, shift_flag, alt_flag, caps_flag, prefix_pending;
  logic    ctrl_next, shift_next, alt_next, caps_next, prefix_next;
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;
  result_t res;
  logic    accept;
  logic    ext;
  logic    is_prefix, is_break, handled, second;
  logic [6:0]  code7;
  logic [13:0] rom_ent;
  logic [6:0]  ch;

  assign scan.ready = !skid_valid;
  assign accept     = scan.valid && scan.ready;

  // decode of the incoming byte
  assign ext       = prefix_pending;
  assign code7     = scan.scan_byte[6:0];
  assign is_prefix = scan.scan_byte == PREFIX_BYTE;
  assign is_break  = scan.scan_byte[7];
  assign handled   = ext ? (code7 == CTRL_MAKE || code7 == ALT_MAKE)
                         : (code7 != 7'h0 && scan.scan_byte < ROM_ROWS);
  assign second    = (!ext && shift_only_key(code7)) ? shift_flag
                                                     : (shift_flag ^ caps_flag);
  assign rom_ent   = key_rom(code7[5:0]);
  assign ch        = second ? rom_ent[13:7] : rom_ent[6:0];

  // flag updates and result assembly
  always_comb begin
    ctrl_next   = ctrl_flag;
    shift_next  = shift_flag;
    alt_next    = alt_flag;
    caps_next   = caps_flag;
    prefix_next = 1'b0;
    res         = '0;
    if (is_prefix) begin
      prefix_next = 1'b1;
    end else if (is_break) begin
      if (code7 == CTRL_MAKE) begin
        ctrl_next = 1'b0;
      end else if (!ext && (code7 == LSHIFT_MAKE || code7 == RSHIFT_MAKE)) begin
        shift_next = 1'b0;
      end else if (code7 == ALT_MAKE) begin
        alt_next = 1'b0;
      end
    end else if (handled) begin
      if (ch != 7'h0) begin
        res.char_valid = 1'b1;
        res.char_code  = ch;
      end else if (code7 == CTRL_MAKE) begin
        ctrl_next = 1'b1;
      end else if (code7 == LSHIFT_MAKE || code7 == RSHIFT_MAKE) begin
        shift_next = 1'b1;
      end else if (code7 == ALT_MAKE) begin
        alt_next = 1'b1;
      end else if (code7 == CAPS_MAKE) begin
        caps_next = !caps_flag;
      end
    end else begin
      res.unknown_key = 1'b1;
    end
    res.ctrl_down  = ctrl_next;
    res.shift_down = shift_next;
    res.alt_down   = alt_next;
    res.caps_on    = caps_next;
  end

  // state flags, result register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_flag      <= 1'b0;
      shift_flag     <= 1'b0;
      alt_flag       <= 1'b0;
      caps_flag      <= 1'b0;
      prefix_pending <= 1'b0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (accept) begin
        ctrl_flag      <= ctrl_next;
        shift_flag     <= shift_next;
        alt_flag       <= alt_next;
        caps_flag      <= caps_next;
        prefix_pending <= prefix_next;
      end
      if (!out_valid || chars.ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!out_valid || chars.ready) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (accept) begin
      skid_data <= res;
    end
  end

  assign chars.valid       = out_valid;
  assign chars.char_valid  = out_data.char_valid;
  assign chars.char_code   = out_data.char_code;
  assign chars.unknown_key = out_data.unknown_key;
  assign chars.ctrl_down   = out_data.ctrl_down;
  assign chars.shift_down  = out_data.shift_down;
  assign chars.alt_down    = out_data.alt_down;
  assign chars.caps_on     = out_data.caps_on;

  // skid holds a beat only behind a stalled result
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid register full while result register empty");

  // a character result never carries the unknown-key flag and is never zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.char_valid) |-> (!out_data.unknown_key && out_data.char_code != 7'h0))
    else $error("malformed character result");

  // an accepted prefix byte arms the prefix flag
  assert property (@(posedge clk) disable iff (rst)
    (accept && is_prefix) |=> prefix_pending)
    else $error("prefix byte did not arm prefix flag");

  // a byte accepted during a stall fills the skid and blocks input
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !chars.ready && accept) |=> !scan.ready)
    else $error("input not blocked after skid fill");

endmodule

>>> sim/scan_code_to_ascii_decoder_checker.sv
`timescale 1ns / 100ps

module scan_code_to_ascii_decoder_checker
  import sc2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sc2a_scan_if        scan,
  sc2a_char_if        chars,
  output int          fail_count,
  output int          backlog,
  output int          n_checked,
  output int          n_chars,
  output int          n_unknown
);

  // keyboard state as the decoder should hold it
  logic ctrl_q;
  logic shift_q;
  logic alt_q;
  logic caps_q;
  logic ext_q;

  // decoded beats still owed by the block, oldest first
  result_t key_results_q[$];

  // character for a handled make code; letters follow shift xor caps lock,
  // every other key picks its second column on shift alone
  function automatic logic [6:0] key_char(input logic [6:0] row, input logic shift,
                                          input logic caps);
    logic [6:0] lc;
    logic [13:0] pair;
    case (row)
      7'h10: lc = 7'h71;
      7'h11: lc = 7'h77;
      7'h12: lc = 7'h65;
      7'h13: lc = 7'h72;
      7'h14: lc = 7'h74;
      7'h15: lc = 7'h79;
      7'h16: lc = 7'h75;
      7'h17: lc = 7'h69;
      7'h18: lc = 7'h6F;
      7'h19: lc = 7'h70;
      7'h1E: lc = 7'h61;
      7'h1F: lc = 7'h73;
      7'h20: lc = 7'h64;
      7'h21: lc = 7'h66;
      7'h22: lc = 7'h67;
      7'h23: lc = 7'h68;
      7'h24: lc = 7'h6A;
      7'h25: lc = 7'h6B;
      7'h26: lc = 7'h6C;
      7'h2C: lc = 7'h7A;
      7'h2D: lc = 7'h78;
      7'h2E: lc = 7'h63;
      7'h2F: lc = 7'h76;
      7'h30: lc = 7'h62;
      7'h31: lc = 7'h6E;
      7'h32: lc = 7'h6D;
      default: lc = 7'h00;
    endcase
    if (lc != 7'h00) begin
      return (shift ^ caps) ? (lc ^ 7'h20) : lc;
    end
    // {plain, shifted}
    case (row)
      7'h01: pair = {7'h1B, 7'h1B};
      7'h02: pair = {7'h31, 7'h21};
      7'h03: pair = {7'h32, 7'h40};
      7'h04: pair = {7'h33, 7'h23};
      7'h05: pair = {7'h34, 7'h24};
      7'h06: pair = {7'h35, 7'h25};
      7'h07: pair = {7'h36, 7'h5E};
      7'h08: pair = {7'h37, 7'h26};
      7'h09: pair = {7'h38, 7'h2A};
      7'h0A: pair = {7'h39, 7'h28};
      7'h0B: pair = {7'h30, 7'h29};
      7'h0C: pair = {7'h2D, 7'h5F};
      7'h0D: pair = {7'h3D, 7'h2B};
      7'h0E: pair = {7'h08, 7'h08};
      7'h0F: pair = {7'h09, 7'h09};
      7'h1A: pair = {7'h5B, 7'h7B};
      7'h1B: pair = {7'h5D, 7'h7D};
      7'h1C: pair = {7'h0D, 7'h0D};
      7'h27: pair = {7'h3B, 7'h3A};
      7'h28: pair = {7'h27, 7'h22};
      7'h29: pair = {7'h60, 7'h7E};
      7'h2B: pair = {7'h5C, 7'h7C};
      7'h33: pair = {7'h2C, 7'h3C};
      7'h34: pair = {7'h2E, 7'h3E};
      7'h35: pair = {7'h2F, 7'h3F};
      7'h37: pair = {7'h2A, 7'h2A};
      7'h39: pair = {7'h20, 7'h20};
      default: pair = 14'h0;
    endcase
    return shift ? pair[6:0] : pair[13:7];
  endfunction

  // decode one scan byte, update the keyboard state, give the beat it causes
  task automatic decode_key_byte(input logic [7:0] b, output result_t r);
    logic       ext;
    logic       unk;
    logic [6:0] ch;
    logic [6:0] low;
    ext = ext_q;
    unk = 1'b0;
    ch  = 7'h00;
    low = b[6:0];
    if (b == PREFIX_BYTE) begin
      ext_q = 1'b1;
    end else begin
      ext_q = 1'b0;
      if (b[7]) begin
        // release: extended shift codes are not shift keys
        if (low == CTRL_MAKE) begin
          ctrl_q = 1'b0;
        end else if (!ext && (low == LSHIFT_MAKE || low == RSHIFT_MAKE)) begin
          shift_q = 1'b0;
        end else if (low == ALT_MAKE) begin
          alt_q = 1'b0;
        end
      end else if (ext ? (low == CTRL_MAKE || low == ALT_MAKE)
                       : (b != 8'h00 && b < ROM_ROWS)) begin
        ch = key_char(low, shift_q, caps_q);
        if (ch == 7'h00) begin
          if (low == CTRL_MAKE) begin
            ctrl_q = 1'b1;
          end else if (low == LSHIFT_MAKE || low == RSHIFT_MAKE) begin
            shift_q = 1'b1;
          end else if (low == ALT_MAKE) begin
            alt_q = 1'b1;
          end else if (low == CAPS_MAKE) begin
            caps_q = ~caps_q;
          end
        end
      end else begin
        unk = 1'b1;
      end
    end
    r.char_valid  = (ch != 7'h00);
    r.char_code   = ch;
    r.unknown_key = unk;
    r.ctrl_down   = ctrl_q;
    r.shift_down  = shift_q;
    r.alt_down    = alt_q;
    r.caps_on     = caps_q;
  endtask

  task automatic check_field(input string name, input logic [6:0] want,
                             input logic [6:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // watch both channels; results leave before the new byte is predicted
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      ctrl_q  = 1'b0;
      shift_q = 1'b0;
      alt_q   = 1'b0;
      caps_q  = 1'b0;
      ext_q   = 1'b0;
      key_results_q.delete();
    end else begin
      if (chars.valid && chars.ready) begin
        got.char_valid  = chars.char_valid;
        got.char_code   = chars.char_code;
        got.unknown_key = chars.unknown_key;
        got.ctrl_down   = chars.ctrl_down;
        got.shift_down  = chars.shift_down;
        got.alt_down    = chars.alt_down;
        got.caps_on     = chars.caps_on;
        n_checked++;
        if (key_results_q.size() == 0) begin
          $error("chars beat with no scan byte outstanding");
          fail_count++;
        end else begin
          want = key_results_q.pop_front();
          check_field("char_valid", 7'(want.char_valid), 7'(got.char_valid));
          check_field("char_code", want.char_code, got.char_code);
          check_field("unknown_key", 7'(want.unknown_key), 7'(got.unknown_key));
          check_field("ctrl_down", 7'(want.ctrl_down), 7'(got.ctrl_down));
          check_field("shift_down", 7'(want.shift_down), 7'(got.shift_down));
          check_field("alt_down", 7'(want.alt_down), 7'(got.alt_down));
          check_field("caps_on", 7'(want.caps_on), 7'(got.caps_on));
          if (want.char_valid) n_chars++;
          if (want.unknown_key) n_unknown++;
        end
      end
      if (scan.valid && scan.ready) begin
        decode_key_byte(scan.scan_byte, want);
        key_results_q.push_back(want);
      end
    end
    backlog = key_results_q.size();
  end

endmodule

>>> sim/scan_code_to_ascii_decoder_top_tb.sv
`timescale 1ns / 100ps

module scan_code_to_ascii_decoder_top_tb;
  import sc2a_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_CYCLES = 12;
  localparam int TOTAL_BYTES = 1125;
  localparam int CYCLE_LIMIT = 100000;

  logic clk;
  logic rst;
  logic stall_en;
  int   sent_count;
  int   cycle_count;
  int   fail_count;
  int   backlog;
  int   n_checked;
  int   n_chars;
  int   n_unknown;

  sc2a_scan_if scan_bus();
  sc2a_char_if char_bus();

  scan_code_to_ascii_decoder_top dut (
    .clk   (clk),
    .rst   (rst),
    .scan  (scan_bus),
    .chars (char_bus)
  );

  scan_code_to_ascii_decoder_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .scan       (scan_bus),
    .chars      (char_bus),
    .fail_count (fail_count),
    .backlog    (backlog),
    .n_checked  (n_checked),
    .n_chars    (n_chars),
    .n_unknown  (n_unknown)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random back-pressure on the result channel
  initial begin
    char_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      char_bus.ready <= !(stall_en && $urandom_range(99) < 38);
    end
  end

  // one scan byte beat, with random gaps ahead of it; call at a falling edge
  task automatic drive_scan_byte(input logic [7:0] b);
    stall_en = !(sent_count >= 450 && sent_count < 700);
    while (stall_en && $urandom_range(99) < 38) begin
      scan_bus.valid <= 1'b0;
      @(negedge clk);
    end
    scan_bus.valid     <= 1'b1;
    scan_bus.scan_byte <= b;
    do @(posedge clk); while (!scan_bus.ready);
    sent_count++;
    @(negedge clk);
  endtask

  // one random keyboard event, mostly well-formed make/break sequences
  task automatic send_key_event();
    int         pick;
    logic [7:0] k;
    pick = $urandom_range(99);
    if (pick < 40) begin
      k = 8'($urandom_range(1, 58));
      drive_scan_byte(k);
      if ($urandom_range(1) == 1) drive_scan_byte(k | 8'h80);
    end else if (pick < 58) begin
      case ($urandom_range(4))
        0: k = {1'b0, LSHIFT_MAKE};
        1: k = {1'b0, RSHIFT_MAKE};
        2: k = {1'b0, CTRL_MAKE};
        3: k = {1'b0, ALT_MAKE};
        default: k = {1'b0, CAPS_MAKE};
      endcase
      if ($urandom_range(3) == 0) drive_scan_byte(PREFIX_BYTE);
      drive_scan_byte(($urandom_range(1) == 1) ? (k | 8'h80) : k);
    end else if (pick < 72) begin
      drive_scan_byte(PREFIX_BYTE);
      drive_scan_byte(8'($urandom_range(255)));
    end else if (pick < 82) begin
      drive_scan_byte(8'($urandom_range(128, 255)));
    end else if (pick < 92) begin
      drive_scan_byte(8'($urandom_range(255)));
    end else begin
      drive_scan_byte(8'($urandom_range(59, 127)));
    end
  endtask

  // stimulus and verdict
  initial begin
    rst                = 1'b1;
    stall_en           = 1'b1;
    sent_count         = 0;
    scan_bus.valid     = 1'b0;
    scan_bus.scan_byte = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // digit plain and shifted, letter under shift and caps lock
    drive_scan_byte(8'h02);
    drive_scan_byte({1'b0, RSHIFT_MAKE});
    drive_scan_byte(8'h02);
    drive_scan_byte(8'h10);
    drive_scan_byte({1'b1, RSHIFT_MAKE});
    drive_scan_byte({1'b0, CAPS_MAKE});
    drive_scan_byte(8'h10);
    drive_scan_byte({1'b0, LSHIFT_MAKE});
    drive_scan_byte(8'h10);
    drive_scan_byte({1'b0, CAPS_MAKE});
    // ctrl, extended right alt, repeated prefix, extended releases
    drive_scan_byte({1'b0, CTRL_MAKE});
    drive_scan_byte(PREFIX_BYTE);
    drive_scan_byte({1'b0, ALT_MAKE});
    drive_scan_byte(PREFIX_BYTE);
    drive_scan_byte(PREFIX_BYTE);
    drive_scan_byte({1'b1, ALT_MAKE});
    drive_scan_byte(PREFIX_BYTE);
    drive_scan_byte({1'b1, CTRL_MAKE});
    // extended shift release leaves shift down; the plain release clears it
    drive_scan_byte(PREFIX_BYTE);
    drive_scan_byte({1'b1, LSHIFT_MAKE});
    drive_scan_byte({1'b1, LSHIFT_MAKE});
    // other extended make, zero byte, first unhandled code, all ones
    drive_scan_byte(PREFIX_BYTE);
    drive_scan_byte(8'h47);
    drive_scan_byte(8'h00);
    drive_scan_byte(ROM_ROWS);
    drive_scan_byte(8'hFF);

    while (sent_count < TOTAL_BYTES) send_key_event();
    scan_bus.valid <= 1'b0;

    // drain
    while (backlog != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("sent %0d scan bytes, checked %0d result beats", sent_count, n_checked);
    $display("results held %0d characters and %0d unknown keys", n_chars, n_unknown);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
